// ----- hw/rtl/min_tracking_stack_defines.svh -----
// Assertion macros shared by the min tracking stack RTL.
// Depends on nothing; compiled out when SYNTHESIS is defined.
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

`ifndef SYNTHESIS

// ante holds at an edge -> cons holds at the same edge
`define MTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante holds at an edge -> cons holds at the next edge
`define MTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MTS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/mts_pkg.sv -----
// Shared types and codes for the min tracking stack.
// No dependencies.
package mts_pkg;

  localparam int VALUE_W  = 32;  // width of push/top/min fields
  localparam int DEPTH_FW = 7;   // width of the depth_now field
  localparam int STATUS_W = 2;

  localparam logic ACTION_PUSH = 1'b0;
  localparam logic ACTION_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

  // Shift command broadcast to every cell of the chain
  typedef struct packed {
    logic push;  // take the entry from the cell above (toward the top)
    logic pop;   // take the entry from the cell below
  } mts_shift_t;

endpackage

// ----- hw/rtl/mts_if.sv -----
// Valid/ready channel interfaces for the min tracking stack.
// Depends on mts_pkg for field widths.
interface mts_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [mts_pkg::VALUE_W-1:0]   push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface mts_out_if;
  logic                          valid;
  logic                          ready;
  logic [mts_pkg::VALUE_W-1:0]   top_value;
  logic [mts_pkg::VALUE_W-1:0]   min_value;
  logic [mts_pkg::DEPTH_FW-1:0]  depth_now;
  logic                          is_empty;
  logic                          is_full;
  logic [mts_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output top_value, output min_value, output depth_now,
                  output is_empty, output is_full, output status, input ready);
  modport sink   (input valid, input top_value, input min_value, input depth_now,
                  input is_empty, input is_full, input status, output ready);
endinterface

// ----- hw/rtl/mts_cell.sv -----
// One stack cell: holds a value and the running minimum at its level.
// Depends on mts_pkg (shift command type).
module mts_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  mts_pkg::mts_shift_t      shift,
  input  logic [DATA_WIDTH-1:0]    above_value,
  input  logic [DATA_WIDTH-1:0]    above_min,
  input  logic [DATA_WIDTH-1:0]    below_value,
  input  logic [DATA_WIDTH-1:0]    below_min,
  output logic [DATA_WIDTH-1:0]    value,
  output logic [DATA_WIDTH-1:0]    run_min
);

  // push and pop never come together; with neither the cell holds
  always_ff @(posedge clk) begin
    if (shift.push) begin
      value   <= above_value;
      run_min <= above_min;
    end else if (shift.pop) begin
      value   <= below_value;
      run_min <= below_min;
    end
  end

endmodule

// ----- hw/rtl/min_tracking_stack.sv -----
// Top level of the min tracking stack: cell chain, depth counter, result register.
// Depends on mts_pkg, mts_if, mts_cell and min_tracking_stack_defines.svh.
`include "min_tracking_stack_defines.svh"

// A LIFO of signed DATA_WIDTH-bit values built as a chain of DEPTH cells;
// cell 0 is the top. Each cell stores its value and the minimum of itself
// and everything beneath it, so the minimum is always read from cell 0. A
// push shifts the whole chain down one cell and a pop shifts it up one;
// one operation is taken every cycle unless the output stalls, and its
// result appears in the output register in the cycle after the transfer. A new item
// is taken whenever the output register is empty or being drained in the
// same cycle. Pop on empty and push on full leave the stack as it is and
// report it in status; top and min read 0 while the stack is empty.
module min_tracking_stack #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch
);

  localparam int DW     = DATA_WIDTH;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VW     = mts_pkg::VALUE_W;
  localparam int DFW    = mts_pkg::DEPTH_FW;
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(DEPTH);

  logic [DW-1:0]    cell_value [DEPTH];
  logic [DW-1:0]    cell_min   [DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic                      res_valid;
  logic [VW-1:0]             res_top;
  logic [VW-1:0]             res_min;
  logic [DFW-1:0]            res_depth;
  logic                      res_empty;
  logic                      res_full;
  logic [mts_pkg::STATUS_W-1:0] res_status;

  logic                      take;
  logic                      is_push;
  logic                      stack_empty;
  logic                      stack_full;
  mts_pkg::mts_shift_t       shift;
  logic [DW-1:0]             new_value;
  logic [DW-1:0]             new_min;
  logic [DW-1:0]             top_next;
  logic [DW-1:0]             min_next;
  logic [mts_pkg::STATUS_W-1:0] status_next;

  assign in_ch.ready = !res_valid || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign is_push     = (in_ch.action == mts_pkg::ACTION_PUSH);
  assign stack_empty = (count == '0);
  assign stack_full  = (count == CntFull);

  assign shift.push = take && is_push && !stack_full;
  assign shift.pop  = take && !is_push && !stack_empty;

  // Sign-extend or truncate the 32-bit field to the stored width
  assign new_value = DW'($signed(in_ch.push_value));

  // Equal values keep the old minimum
  always_comb begin
    new_min = new_value;
    if (!stack_empty && !($signed(new_value) < $signed(cell_min[0]))) begin
      new_min = cell_min[0];
    end
  end

  always_comb begin
    count_next  = count;
    top_next    = cell_value[0];
    min_next    = cell_min[0];
    status_next = mts_pkg::STATUS_OK;
    priority if (shift.push) begin
      count_next = count + 1'b1;
      top_next   = new_value;
      min_next   = new_min;
    end else if (shift.pop) begin
      count_next = count - 1'b1;
      top_next   = cell_value[1];
      min_next   = cell_min[1];
    end else if (is_push) begin
      status_next = mts_pkg::STATUS_PUSH_FULL;
    end else begin
      status_next = mts_pkg::STATUS_POP_EMPTY;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DW-1:0] above_value;
    logic [DW-1:0] above_min;
    logic [DW-1:0] below_value;
    logic [DW-1:0] below_min;

    if (i == 0) begin : g_top
      assign above_value = new_value;
      assign above_min   = new_min;
    end else begin : g_mid_up
      assign above_value = cell_value[i-1];
      assign above_min   = cell_min[i-1];
    end

    // bottom cell keeps its content on a pop; it lies past the count then
    if (i == DEPTH - 1) begin : g_bottom
      assign below_value = cell_value[i];
      assign below_min   = cell_min[i];
    end else begin : g_mid_down
      assign below_value = cell_value[i+1];
      assign below_min   = cell_min[i+1];
    end

    mts_cell #(
      .DATA_WIDTH (DW)
    ) u_cell (
      .clk         (clk),
      .shift       (shift),
      .above_value (above_value),
      .above_min   (above_min),
      .below_value (below_value),
      .below_min   (below_min),
      .value       (cell_value[i]),
      .run_min     (cell_min[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_depth  <= DFW'(count_next);
      res_empty  <= (count_next == '0);
      res_full   <= (count_next == CntFull);
      res_status <= status_next;
      if (count_next == '0) begin
        res_top <= '0;
        res_min <= '0;
      end else begin
        res_top <= VW'($signed(top_next));
        res_min <= VW'($signed(min_next));
      end
    end
  end

  assign out_ch.valid     = res_valid;
  assign out_ch.top_value = res_top;
  assign out_ch.min_value = res_min;
  assign out_ch.depth_now = res_depth;
  assign out_ch.is_empty  = res_empty;
  assign out_ch.is_full   = res_full;
  assign out_ch.status    = res_status;

  `MTS_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CntFull, "entry count above depth")
  `MTS_ASSERT_NEXT(a_push_count, clk, rst, shift.push,
                   count == $past(count) + 1'b1, "push did not grow stack")
  `MTS_ASSERT_NEXT(a_pop_empty, clk, rst, take && !is_push && stack_empty,
                   res_status == mts_pkg::STATUS_POP_EMPTY && res_empty,
                   "pop on empty not flagged")
  `MTS_ASSERT_IMP(a_min_le_top, clk, rst, !stack_empty,
                  $signed(cell_min[0]) <= $signed(cell_value[0]),
                  "running minimum above top value")

endmodule
